FILE: src/tsm_pkg.sv
package tsm_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int H_W      = 16;
  localparam int COORD_W  = 8;
  localparam int DIM_REG_W = 9;
  localparam int DIM_W    = 11;
  localparam int CNT_W    = 4;
  localparam int NCELL    = 9;
  localparam int CELL_W   = 4;
  localparam int MASK_W   = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]  LAST_READ = '1;
  localparam logic [CNT_W-1:0]  LAST_DRAIN = CNT_W'(1);
  localparam logic [CELL_W-1:0] CELL_CENTRE = CELL_W'(4);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH   = 2'd0,
    CFG_MAP_HEIGHT  = 2'd1,
    CFG_SLOPE_LIMIT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic             wr_go;
    logic             commit;
    logic             commit_query;
  } seq_ctl_t;

  // window slot (row-major 4x4, top-left at col-1,row-1) -> cell index row*3+col
  function automatic logic [CELL_W-1:0] cell_of(input logic [CNT_W-1:0] n);
    logic [1:0] ci;
    logic [1:0] cj;
    ci = n[1:0] - 2'd1;
    cj = n[3:2] - 2'd1;
    return CELL_W'(cj) * CELL_W'(3) + CELL_W'(ci);
  endfunction

  // neighbour order N,NE,E,SE,S,SW,W,NW
  function automatic logic [CELL_W-1:0] nbr_cell(input int k);
    logic [CELL_W-1:0] c;
    case (k)
      0:       c = CELL_W'(1);
      1:       c = CELL_W'(2);
      2:       c = CELL_W'(5);
      3:       c = CELL_W'(8);
      4:       c = CELL_W'(7);
      5:       c = CELL_W'(6);
      6:       c = CELL_W'(3);
      default: c = CELL_W'(0);
    endcase
    return c;
  endfunction

endpackage

FILE: src/terrain_slope_movement_mask_unit.sv
// Terrain slope movement mask. Holds a height raster of MAX_COLS x MAX_ROWS
// 16-bit samples in one single-port memory; its contents are undefined after
// reset and a query may only touch fields that were written. A write
// (in_tuser = 0) stores one sample and returns an all-zero result through
// the write-done state and the output register. A query (in_tuser = 1)
// reads the 4x4 height window around (col,row), one read per cycle from the
// memory port, evaluates each 2x2 cell as its last sample arrives, and
// returns the mask through the read, drain and finish states and the output
// register. One item is in work at a time; the next input transfer is taken
// while a result waits in the output register.
module terrain_slope_movement_mask_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // col[7:0], row[15:8], height_value[31:16]
  input  logic [tsm_pkg::IN_DATA_W-1:0]  in_tdata,
  // command[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // move_mask[7:0], centre_passable[8], zero fill [15:9]
  output logic [tsm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [tsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tsm_pkg::*;

  logic [DIM_REG_W-1:0] map_width_r, map_height_r;
  logic [H_W-1:0]       slope_limit_r;
  logic [DIM_W-1:0]     width_eff, height_eff;

  logic [COORD_W-1:0]   in_col, in_row, q_col_r, q_row_r;
  logic [H_W-1:0]       in_height;

  seq_ctl_t             ctl;
  logic                 slot_free;
  logic                 in_fire;

  logic                 ram_en, ram_we;
  logic [ADDR_W-1:0]    ram_addr, rd_addr, wr_addr;
  logic [H_W-1:0]       ram_rdata;
  logic [DIM_W-1:0]     colx, rowx;
  logic                 wr_in_store;

  logic [NCELL-1:0]     pass;
  logic [MASK_W-1:0]    mask;
  logic                 border;

  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign in_col    = in_tdata[7:0];
  assign in_row    = in_tdata[15:8];
  assign in_height = in_tdata[31:16];
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r   <= DIM_REG_W'(256);
      map_height_r  <= DIM_REG_W'(256);
      slope_limit_r <= H_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAP_WIDTH:   map_width_r   <= cfg_wdata[DIM_REG_W-1:0];
        CFG_MAP_HEIGHT:  map_height_r  <= cfg_wdata[DIM_REG_W-1:0];
        CFG_SLOPE_LIMIT: slope_limit_r <= cfg_wdata;
        CFG_UNUSED:      ;
      endcase
    end
  end

  assign width_eff  = (DIM_W'(map_width_r) > DIM_W'(MAX_COLS)) ?
                      DIM_W'(MAX_COLS) : DIM_W'(map_width_r);
  assign height_eff = (DIM_W'(map_height_r) > DIM_W'(MAX_ROWS)) ?
                      DIM_W'(MAX_ROWS) : DIM_W'(map_height_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_col_r <= in_col;
      q_row_r <= in_row;
    end
  end

  tsm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .slot_free (slot_free),
    .in_ready  (in_tready),
    .ctl       (ctl)
  );

  // window slot i,j -> field (col-1+i, row-1+j); off-store slots read entry 0
  assign colx = DIM_W'(q_col_r) + DIM_W'(ctl.rd_idx[1:0]) - DIM_W'(1);
  assign rowx = DIM_W'(q_row_r) + DIM_W'(ctl.rd_idx[3:2]) - DIM_W'(1);
  assign rd_addr = ((colx < DIM_W'(MAX_COLS)) && (rowx < DIM_W'(MAX_ROWS))) ?
                   ADDR_W'(32'(rowx) * MAX_COLS + 32'(colx)) : '0;

  assign wr_in_store = (DIM_W'(in_col) < DIM_W'(MAX_COLS)) &&
                       (DIM_W'(in_row) < DIM_W'(MAX_ROWS));
  assign wr_addr     = ADDR_W'(32'(in_row) * MAX_COLS + 32'(in_col));

  assign ram_we   = ctl.wr_go && wr_in_store;
  assign ram_en   = ram_we || ctl.rd_en;
  assign ram_addr = ram_we ? wr_addr : rd_addr;

  tsm_ram #(
    .WIDTH (H_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_height),
    .rdata (ram_rdata)
  );

  tsm_slope u_slope (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (ctl.rd_en),
    .rd_idx      (ctl.rd_idx),
    .rdata       (ram_rdata),
    .q_col       (q_col_r),
    .q_row       (q_row_r),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .slope_limit (slope_limit_r),
    .pass        (pass)
  );

  assign border = (q_col_r == '0) || (q_row_r == '0) ||
                  (DIM_W'(q_col_r) + DIM_W'(1) >= width_eff) ||
                  (DIM_W'(q_row_r) + DIM_W'(1) >= height_eff);

  always_comb begin
    mask = '0;
    if (pass[CELL_CENTRE] && !border) begin
      for (int k = 0; k < MASK_W; k++) begin
        mask[k] = pass[nbr_cell(k)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_data_r <= ctl.commit_query ?
                    {{(OUT_DATA_W-MASK_W-1){1'b0}}, pass[CELL_CENTRE], mask} : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/tsm_ram.sv
module tsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: src/tsm_seq.sv
module tsm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  logic              slot_free,
  output logic              in_ready,
  output tsm_pkg::seq_ctl_t ctl
);
  import tsm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_WDONE = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    in_ready         = 1'b0;
    ctl              = '0;
    ctl.rd_idx       = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt = '0;
          if (in_cmd == CMD_QUERY) begin
            state_nxt = ST_READ;
          end else begin
            ctl.wr_go = 1'b1;
            state_nxt = ST_WDONE;
          end
        end
      end
      ST_READ: begin
        ctl.rd_en = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_READ) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_DRAIN) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          ctl.commit       = 1'b1;
          ctl.commit_query = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_WDONE: begin
        if (slot_free) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: src/tsm_slope.sv
module tsm_slope (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [tsm_pkg::CNT_W-1:0]   rd_idx,
  input  logic [tsm_pkg::H_W-1:0]     rdata,
  input  logic [tsm_pkg::COORD_W-1:0] q_col,
  input  logic [tsm_pkg::COORD_W-1:0] q_row,
  input  logic [tsm_pkg::DIM_W-1:0]   width_eff,
  input  logic [tsm_pkg::DIM_W-1:0]   height_eff,
  input  logic [tsm_pkg::H_W-1:0]     slope_limit,
  output logic [tsm_pkg::NCELL-1:0]   pass
);
  import tsm_pkg::*;

  logic             ld_vld_r;
  logic [CNT_W-1:0] ld_idx_r;
  logic [H_W-1:0]   sh_r [5];

  logic             a_vld_r;
  logic [CELL_W-1:0] a_cell_r;
  logic             a_inmap_r;
  logic [H_W-1:0]   a_hi_r, a_lo_r;
  logic [NCELL-1:0] pass_r;

  logic             cell_done;
  logic [H_W-1:0]   hx0, hx1, ln0, ln1, hi, lo;
  logic [DIM_W-1:0] fcp, frp;
  logic             inmap;
  logic             a_ok;

  // heights of the cell completed by this slot: n-5, n-4, n-1, n
  assign cell_done = ld_vld_r && (ld_idx_r[1:0] != 2'd0) && (ld_idx_r[3:2] != 2'd0);
  assign hx0 = (sh_r[4] > sh_r[3]) ? sh_r[4] : sh_r[3];
  assign hx1 = (sh_r[0] > rdata)   ? sh_r[0] : rdata;
  assign ln0 = (sh_r[4] < sh_r[3]) ? sh_r[4] : sh_r[3];
  assign ln1 = (sh_r[0] < rdata)   ? sh_r[0] : rdata;
  assign hi  = (hx0 > hx1) ? hx0 : hx1;
  assign lo  = (ln0 < ln1) ? ln0 : ln1;

  // field coordinate plus one, must lie in 1 .. size-1
  assign fcp   = DIM_W'(q_col) + DIM_W'(ld_idx_r[1:0]) - DIM_W'(1);
  assign frp   = DIM_W'(q_row) + DIM_W'(ld_idx_r[3:2]) - DIM_W'(1);
  assign inmap = (fcp != '0) && (fcp < width_eff) && (frp != '0) && (frp < height_eff);

  assign a_ok = a_inmap_r && ((a_hi_r - a_lo_r) < slope_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_vld_r <= 1'b0;
      a_vld_r  <= 1'b0;
    end else begin
      ld_vld_r <= rd_en;
      a_vld_r  <= cell_done;
    end
  end

  always_ff @(posedge clk) begin
    ld_idx_r <= rd_idx;
    if (ld_vld_r) begin
      sh_r[0] <= rdata;
      sh_r[1] <= sh_r[0];
      sh_r[2] <= sh_r[1];
      sh_r[3] <= sh_r[2];
      sh_r[4] <= sh_r[3];
    end
    if (cell_done) begin
      a_cell_r  <= cell_of(ld_idx_r);
      a_inmap_r <= inmap;
      a_hi_r    <= hi;
      a_lo_r    <= lo;
    end
    for (int i = 0; i < NCELL; i++) begin
      if (a_vld_r && (a_cell_r == CELL_W'(i))) begin
        pass_r[i] <= a_ok;
      end
    end
  end

  assign pass = pass_r;

endmodule

FILE: src/tsm_checker.sv
module tsm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tsm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tsm_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer taken while busy");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_WRITE) && !out_tvalid
    |=> ##1 out_tvalid && (out_tdata == '0))
    else $error("write result missing or nonzero");

  a_mask_needs_centre: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] != '0) |-> out_tdata[8])
    else $error("mask set on impassable centre");

endmodule

bind terrain_slope_movement_mask_unit tsm_checker u_tsm_checker (.*);

FILE: tb/tb_terrain_slope_movement_mask_unit.sv
module tb_terrain_slope_movement_mask_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tsm_pkg::*;

  localparam int LIMIT_CYCLES    = 1_000_000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int N_DIRECTED      = 18;
  localparam int HOLD_CYCLES     = 300;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              centre;
  } mask_result_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        col;
    logic [7:0]        row;
    logic [H_W-1:0]    hv;
    logic              known;
    logic [MASK_W-1:0] mask;
    logic              centre;
  } dir_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_MAP_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  terrain_slope_movement_mask_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the height raster and registers
  logic [H_W-1:0]       heights [DEPTH];
  bit                   written [DEPTH];
  logic [DIM_REG_W-1:0] map_w_q = 9'd256;
  logic [DIM_REG_W-1:0] map_h_q = 9'd256;
  logic [H_W-1:0]       slope_q = 16'd256;

  // N, NE, E, SE, S, SW, W, NW
  int col_step [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
  int row_step [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};

  mask_result_t pending_masks [$];
  int           items_sent = 0;
  int           errors     = 0;
  int           cycles     = 0;
  int           stall_left = 0;
  bit           calm       = 1'b0;
  bit           hold_req   = 1'b0;
  int           base_h     = 1000;
  int           spread_h   = 50;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_WRITE, 8'd0,   8'd0,   16'h0000, 1'b1, 8'h00, 1'b0},
    '{CMD_WRITE, 8'd255, 8'd255, 16'hFFFF, 1'b1, 8'h00, 1'b0},
    '{CMD_WRITE, 8'd255, 8'd0,   16'hA5A5, 1'b1, 8'h00, 1'b0},
    '{CMD_WRITE, 8'd0,   8'd255, 16'h5A5A, 1'b1, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd255, 8'd255, 16'h1234, 1'b1, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd0,   16'hFFFF, 1'b0, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd255, 8'd0,   16'h0000, 1'b1, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd0,   8'd255, 16'h0000, 1'b1, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd5,   8'd5,   16'hFFFF, 1'b0, 8'h00, 1'b0},
    '{CMD_WRITE, 8'd6,   8'd4,   16'd60000, 1'b1, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd5,   8'd5,   16'h0000, 1'b0, 8'h00, 1'b0},
    '{CMD_WRITE, 8'd4,   8'd6,   16'h0000, 1'b1, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd5,   8'd5,   16'h0000, 1'b0, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd254, 8'd254, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd253, 8'd253, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{CMD_WRITE, 8'd128, 8'd128, 16'h8000, 1'b1, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd127, 8'd127, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{CMD_QUERY, 8'd128, 8'd128, 16'h0000, 1'b0, 8'h00, 1'b0}
  };

  function automatic int eff_dim(logic [DIM_REG_W-1:0] v, int limit);
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  function automatic bit cell_passable(int c, int r);
    int w, h;
    logic [H_W-1:0] a, b, d, e, hi, lo;
    w = eff_dim(map_w_q, MAX_COLS);
    h = eff_dim(map_h_q, MAX_ROWS);
    if (c < 0 || r < 0) return 1'b0;
    if (c + 1 >= w || r + 1 >= h) return 1'b0;
    a = heights[r * MAX_COLS + c];
    b = heights[r * MAX_COLS + c + 1];
    d = heights[(r + 1) * MAX_COLS + c];
    e = heights[(r + 1) * MAX_COLS + c + 1];
    hi = a;
    lo = a;
    if (b > hi) hi = b;
    if (d > hi) hi = d;
    if (e > hi) hi = e;
    if (b < lo) lo = b;
    if (d < lo) lo = d;
    if (e < lo) lo = e;
    return (hi - lo) < slope_q;
  endfunction

  function automatic mask_result_t predict_mask(cmd_t cmd, int c, int r, logic [H_W-1:0] hv);
    mask_result_t res;
    int w, h;
    res = '0;
    if (cmd == CMD_WRITE) begin
      heights[r * MAX_COLS + c] = hv;
      written[r * MAX_COLS + c] = 1'b1;
      return res;
    end
    w = eff_dim(map_w_q, MAX_COLS);
    h = eff_dim(map_h_q, MAX_ROWS);
    res.centre = cell_passable(c, r);
    if (res.centre && c >= 1 && r >= 1 && c + 1 < w && r + 1 < h) begin
      for (int k = 0; k < 8; k++) begin
        if (cell_passable(c + col_step[k], r + row_step[k])) res.mask[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic int idle_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [H_W-1:0] pick_height();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 16'($urandom);
    if (p < 6) return 16'h0000;
    if (p < 8) return 16'hFFFF;
    return 16'(base_h + $urandom_range(0, spread_h));
  endfunction

  function automatic int rim_coord(int n);
    int v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 1;
      2:       v = n - 2;
      3:       v = n - 1;
      4:       v = n;
      default: v = 255;
    endcase
    return v & 255;
  endfunction

  task automatic send_item(cmd_t cmd, int c, int r, logic [H_W-1:0] hv,
                           bit fixed = 1'b0, logic [MASK_W-1:0] fmask = '0,
                           logic fcentre = 1'b0);
    int gap;
    mask_result_t res;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {hv, 8'(r), 8'(c)};
    do @(posedge clk); while (!in_tready);
    res = predict_mask(cmd, c, r, hv);
    if (fixed) res = '{mask: fmask, centre: fcentre};
    pending_masks = {pending_masks, res};
    items_sent++;
  endtask

  // a query may only read samples that exist; cover the 4x4 window, wrapped
  task automatic fill_window(int c, int r);
    int cc, rr, dr, dc;
    for (dr = -1; dr <= 2; dr++) begin
      for (dc = -1; dc <= 2; dc++) begin
        cc = (c + dc) & 255;
        rr = (r + dr) & 255;
        if (!written[rr * MAX_COLS + cc]) send_item(CMD_WRITE, cc, rr, pick_height());
      end
    end
  endtask

  task automatic query_field(int c, int r);
    fill_window(c, r);
    send_item(CMD_QUERY, c, r, 16'($urandom));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_MAP_WIDTH:   map_w_q = v[DIM_REG_W-1:0];
      CFG_MAP_HEIGHT:  map_h_q = v[DIM_REG_W-1:0];
      CFG_SLOPE_LIMIT: slope_q = v;
      default: ;
    endcase
  endtask

  task automatic configure(int w, int h, int s);
    // upper bits of the size registers are junk that must be dropped
    put_reg(CFG_MAP_WIDTH, {7'($urandom), 9'(w)});
    put_reg(CFG_MAP_HEIGHT, {7'($urandom), 9'(h)});
    put_reg(CFG_SLOPE_LIMIT, 16'(s));
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_terrain_slope_movement_mask_unit: errors");
      $finish;
    end
  end

  // result side: check each transfer, then pick next tready
  always @(posedge clk) begin : result_sink
    mask_result_t want;
    if (out_tvalid && out_tready) begin
      if (pending_masks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
      end else begin
        want = pending_masks.pop_front();
        if (out_tdata[7:0] !== want.mask) begin
          errors++;
          $display("%0t: move_mask expected %h got %h", $time, want.mask, out_tdata[7:0]);
        end
        if (out_tdata[8] !== want.centre) begin
          errors++;
          $display("%0t: centre_passable expected %b got %b", $time, want.centre,
                   out_tdata[8]);
        end
        if (out_tdata[15:9] !== '0) begin
          errors++;
          $display("%0t: fill bits expected 0 got %h", $time, out_tdata[15:9]);
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left = idle_len();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    int pw [PHASES];
    int ph [PHASES];
    int ps [PHASES];
    int w, h, s, we, he, lo_c, lo_r, start, op, sel, c, r;
    dir_row_t row_d;

    pw = '{256, 3, 256, 20, 511, 0, -1, -1, 256, 40};
    ph = '{256, 3, 256, 12, 300, 2, -1, -1, 256, 256};
    ps = '{256, 65535, 0, 1, 1000, 500, -1, -1, 65535, 300};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row_d = directed_rows[i];
      if (row_d.cmd == CMD_QUERY) fill_window(row_d.col, row_d.row);
      send_item(row_d.cmd, row_d.col, row_d.row, row_d.hv, row_d.known, row_d.mask,
                row_d.centre);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      w = (pw[p] < 0) ? $urandom_range(3, 256) : pw[p];
      h = (ph[p] < 0) ? $urandom_range(3, 256) : ph[p];
      s = (ps[p] < 0) ? $urandom_range(0, 2000) : ps[p];
      configure(w, h, s);
      we = eff_dim(9'(w), MAX_COLS);
      he = eff_dim(9'(h), MAX_ROWS);
      spread_h = (s == 0) ? 64 : s + s / 4 + 1;
      if (spread_h > 65535) spread_h = 65535;
      base_h = $urandom_range(0, 65535 - spread_h);
      lo_c = (we > 10) ? $urandom_range(0, we - 8) : 0;
      lo_r = (he > 10) ? $urandom_range(0, he - 8) : 0;
      calm = ($urandom_range(0, 3) == 0);
      if (p == 2 || p == 6) begin
        calm = 1'b0;
        hold_req = 1'b1;
      end
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        op = $urandom_range(0, 99);
        if (op < 40) begin
          send_item(CMD_WRITE, (lo_c + $urandom_range(0, 7)) & 255,
                    (lo_r + $urandom_range(0, 7)) & 255, pick_height());
        end else if (op < 48) begin
          send_item(CMD_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                    16'($urandom));
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 65) begin
            c = (lo_c + $urandom_range(0, 7)) & 255;
            r = (lo_r + $urandom_range(0, 7)) & 255;
          end else if (sel < 92) begin
            c = rim_coord(we);
            r = rim_coord(he);
          end else begin
            c = $urandom_range(0, 255);
            r = $urandom_range(0, 255);
          end
          query_field(c, r);
        end
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_terrain_slope_movement_mask_unit: clean");
    end else begin
      $display("tb_terrain_slope_movement_mask_unit: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tsm_pkg.sv
src/tsm_ram.sv
src/tsm_seq.sv
src/tsm_slope.sv
src/terrain_slope_movement_mask_unit.sv
src/tsm_checker.sv
tb/tb_terrain_slope_movement_mask_unit.sv
